### rtl/hbm_pkg.sv
// Shared types, codes and helpers for the heartbeat liveness monitor.
// Used by hbm_cfg, hbm_rules and heartbeat_liveness_monitor; no dependencies.
package hbm_pkg;

    localparam int TIME_BITS = 48;
    localparam int CFG_BITS  = 32;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_QUERY_INTERVAL   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_WARNING_INTERVAL = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_DEAD_INTERVAL    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_RESTART_WAIT     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_REPORT_INTERVAL  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_AUTO_RESTART     = 3'd5;

    localparam logic [CFG_BITS-1:0] RST_QUERY_INTERVAL   = 32'd2000000;
    localparam logic [CFG_BITS-1:0] RST_WARNING_INTERVAL = 32'd4000000;
    localparam logic [CFG_BITS-1:0] RST_DEAD_INTERVAL    = 32'd6000000;
    localparam logic [CFG_BITS-1:0] RST_RESTART_WAIT     = 32'd3000000;
    localparam logic [CFG_BITS-1:0] RST_REPORT_INTERVAL  = 32'd2000000;

    localparam logic [1:0] ACT_POLL   = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_REPLY  = 2'd2;
    localparam logic [1:0] ACT_MANUAL = 2'd3;

    localparam logic [2:0] H_ALIVE   = 3'd0;
    localparam logic [2:0] H_WAITING = 3'd1;
    localparam logic [2:0] H_DELAYED = 3'd2;
    localparam logic [2:0] H_DEAD    = 3'd3;
    localparam logic [2:0] H_START   = 3'd4;

    typedef enum logic [4:0] {
        ST_ALIVE   = 5'b00001,
        ST_WAITING = 5'b00010,
        ST_DELAYED = 5'b00100,
        ST_DEAD    = 5'b01000,
        ST_START   = 5'b10000
    } health_st_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] query_interval;
        logic [CFG_BITS-1:0] warning_interval;
        logic [CFG_BITS-1:0] dead_interval;
        logic [CFG_BITS-1:0] restart_wait;
        logic [CFG_BITS-1:0] report_interval;
        logic                auto_restart;
    } hbm_cfg_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [TIME_BITS-1:0] now;
    } hbm_in_t;

    typedef struct packed {
        logic       send_query;
        logic       start_component;
        logic       manual_start;
        logic       send_status;
        logic [2:0] health;
    } hbm_out_t;

    typedef struct packed {
        health_st_t           health;
        logic [TIME_BITS-1:0] last_query_time;
        logic [TIME_BITS-1:0] restart_request_time;
        logic [TIME_BITS-1:0] last_report_time;
        logic                 manual_start_pending;
    } hbm_state_t;

    function automatic logic [2:0] health_code(input health_st_t st);
        logic [2:0] code;
        case (st)
            ST_ALIVE:   code = H_ALIVE;
            ST_WAITING: code = H_WAITING;
            ST_DELAYED: code = H_DELAYED;
            ST_DEAD:    code = H_DEAD;
            ST_START:   code = H_START;
            default:    code = H_ALIVE;
        endcase
        return code;
    endfunction

    // now - since >= span; a stamp ahead of now never reaches
    function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                     input logic [TIME_BITS-1:0] since,
                                     input logic [CFG_BITS-1:0]  span);
        logic [TIME_BITS-1:0] diff;
        diff = now - since;
        return (now >= since) && (diff >= TIME_BITS'(span));
    endfunction

    // now - since > span; a stamp at or ahead of now never passes
    function automatic logic passed(input logic [TIME_BITS-1:0] now,
                                    input logic [TIME_BITS-1:0] since,
                                    input logic [CFG_BITS-1:0]  span);
        logic [TIME_BITS-1:0] diff;
        diff = now - since;
        return (now > since) && (diff > TIME_BITS'(span));
    endfunction

endpackage

### rtl/hbm_cfg.sv
// Configuration register file of the heartbeat liveness monitor.
// Depends on hbm_pkg for register indexes, reset values and hbm_cfg_t.
module hbm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hbm_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [hbm_pkg::CFG_BITS-1:0]  cfg_data,
    output hbm_pkg::hbm_cfg_t             cfg
);
    import hbm_pkg::*;

    hbm_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.query_interval   <= RST_QUERY_INTERVAL;
            cfg_reg.warning_interval <= RST_WARNING_INTERVAL;
            cfg_reg.dead_interval    <= RST_DEAD_INTERVAL;
            cfg_reg.restart_wait     <= RST_RESTART_WAIT;
            cfg_reg.report_interval  <= RST_REPORT_INTERVAL;
            cfg_reg.auto_restart     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUERY_INTERVAL:   cfg_reg.query_interval   <= cfg_data;
                REG_WARNING_INTERVAL: cfg_reg.warning_interval <= cfg_data;
                REG_DEAD_INTERVAL:    cfg_reg.dead_interval    <= cfg_data;
                REG_RESTART_WAIT:     cfg_reg.restart_wait     <= cfg_data;
                REG_REPORT_INTERVAL:  cfg_reg.report_interval  <= cfg_data;
                REG_AUTO_RESTART:     cfg_reg.auto_restart     <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/hbm_rules.sv
// Per-event logic: query, restart and report rules and the non-poll events.
// Depends on hbm_pkg for the item, result, state and configuration types.
module hbm_rules (
    input  hbm_pkg::hbm_in_t    item,
    input  hbm_pkg::hbm_state_t cur,
    input  hbm_pkg::hbm_cfg_t   cfg,
    output hbm_pkg::hbm_state_t nxt,
    output hbm_pkg::hbm_out_t   res
);
    import hbm_pkg::*;

    always_comb
    begin
        nxt = cur;
        res = '0;
        case (item.action)
            ACT_POLL:
            begin
                case (cur.health)
                    ST_ALIVE:
                    begin
                        if (reached(item.now, cur.last_query_time, cfg.query_interval))
                        begin
                            nxt.health     = ST_WAITING;
                            res.send_query = 1'b1;
                        end
                    end
                    ST_WAITING:
                    begin
                        if (reached(item.now, cur.last_query_time, cfg.warning_interval))
                        begin
                            nxt.health     = ST_DELAYED;
                            res.send_query = 1'b1;
                        end
                    end
                    ST_DELAYED:
                    begin
                        if (reached(item.now, cur.last_query_time, cfg.dead_interval))
                            nxt.health = ST_DEAD;
                    end
                    ST_START:
                    begin
                        if (reached(item.now, cur.restart_request_time, cfg.restart_wait))
                            nxt.health = ST_ALIVE;
                    end
                    default: ;
                endcase

                res.manual_start = cur.manual_start_pending;
                if (nxt.health == ST_DEAD && (cfg.auto_restart || cur.manual_start_pending))
                begin
                    nxt.manual_start_pending = 1'b0;
                    nxt.health               = ST_START;
                    nxt.restart_request_time = item.now;
                    res.start_component      = 1'b1;
                end

                if (passed(item.now, cur.last_report_time, cfg.report_interval))
                begin
                    nxt.last_report_time = item.now;
                    res.send_status      = 1'b1;
                end
            end
            ACT_QUERY:
                nxt.last_query_time = item.now;
            ACT_REPLY:
            begin
                nxt.health               = ST_ALIVE;
                nxt.manual_start_pending = 1'b0;
            end
            default:
                nxt.manual_start_pending = 1'b1;
        endcase
        res.health = health_code(nxt.health);
    end

endmodule

### rtl/heartbeat_liveness_monitor.sv
// Heartbeat liveness monitor for one watched component.
// Input channel in_*: one event (poll, query sent, reply received, manual
// start) with its microsecond time stamp per transfer.
// Output channel out_*: one result per event, in order: query and start
// requests, the pending manual start flag, the status report flag and the
// health code after the event.
// Configuration channel cfg_*: register index and 32-bit data; cfg_ready is
// always high. Write only while no event is in flight.
// Pipeline: an event passes the input register, then the result register.
// Throughput: one event per cycle while out_ready does not hold a result back,
// set by the combinational rule logic between the two registers; the health
// state and time stamps update on the same edge the result is registered.
// Reset: health alive, all time stamps zero, no manual start pending,
// registers at their defaults; both pipeline stages empty.
// Stall: a held result keeps the input register full; in_ready drops only
// when both stages hold an event and out_ready is low.
// Depends on hbm_pkg, hbm_cfg and hbm_rules.
module heartbeat_liveness_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hbm_pkg::hbm_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hbm_pkg::hbm_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hbm_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [hbm_pkg::CFG_BITS-1:0]  cfg_data
);
    import hbm_pkg::*;

    hbm_cfg_t   cfg;
    logic       s1_valid_reg;
    hbm_in_t    s1_item_reg;
    logic       out_valid_reg;
    hbm_out_t   out_data_reg;
    hbm_state_t state_reg;
    hbm_state_t state_next;
    hbm_out_t   res_next;
    logic       advance;

    hbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hbm_rules u_rules (
        .item (s1_item_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{health: ST_ALIVE, default: '0};
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_data;
        if (advance)
            out_data_reg <= res_next;
    end

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input refused with an empty input stage");

    a_start_health: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.start_component |-> out_data_reg.health == H_START)
        else $error("start request without start-requested health");

    a_query_health: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.send_query
            |-> out_data_reg.health == H_WAITING || out_data_reg.health == H_DELAYED)
        else $error("query request outside waiting or delayed");

    a_start_clears_manual: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.start_component |=> !state_reg.manual_start_pending)
        else $error("manual start still pending after a start request");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> $onehot(state_reg.health))
        else $error("health state lost its one-hot code");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for heartbeat_liveness_monitor: directed walks through the health
// states, then random event streams under idle, stall and backpressure, checked per result.
// Depends on hbm_pkg and the heartbeat_liveness_monitor RTL.
module tb_top;
    import hbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_BITS-1:0] CFG_ALL_ONES = '1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    hbm_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    hbm_out_t            out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    heartbeat_liveness_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted register file and liveness state
    logic [CFG_BITS-1:0]  pr_query_iv;
    logic [CFG_BITS-1:0]  pr_warn_iv;
    logic [CFG_BITS-1:0]  pr_dead_iv;
    logic [CFG_BITS-1:0]  pr_restart_wait;
    logic [CFG_BITS-1:0]  pr_report_iv;
    logic                 pr_auto;
    logic [2:0]           pr_health;
    logic [TIME_BITS-1:0] pr_last_query;
    logic [TIME_BITS-1:0] pr_restart_at;
    logic [TIME_BITS-1:0] pr_last_report;
    logic                 pr_manual;

    hbm_out_t             expected_results[$];
    hbm_out_t             want;
    int                   mismatch_count = 0;
    int                   results_seen = 0;
    int                   items_sent = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left = 0;
    int                   idle_cycles = 0;
    logic [TIME_BITS-1:0] cur_time = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic span_reached(input logic [TIME_BITS-1:0] now,
                                          input logic [TIME_BITS-1:0] since,
                                          input logic [CFG_BITS-1:0]  span);
        logic [TIME_BITS-1:0] gap;
        gap = now - since;
        if (now < since)
            return 1'b0;
        return gap >= {{(TIME_BITS-CFG_BITS){1'b0}}, span};
    endfunction

    function automatic logic span_passed(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] since,
                                         input logic [CFG_BITS-1:0]  span);
        logic [TIME_BITS-1:0] gap;
        gap = now - since;
        if (now <= since)
            return 1'b0;
        return gap > {{(TIME_BITS-CFG_BITS){1'b0}}, span};
    endfunction

    function automatic hbm_out_t predict_liveness(input hbm_in_t ev);
        hbm_out_t r;
        r = '0;
        case (ev.action)
            ACT_POLL:
            begin
                case (pr_health)
                    H_ALIVE:
                        if (span_reached(ev.now, pr_last_query, pr_query_iv))
                        begin
                            pr_health = H_WAITING;
                            r.send_query = 1'b1;
                        end
                    H_WAITING:
                        if (span_reached(ev.now, pr_last_query, pr_warn_iv))
                        begin
                            pr_health = H_DELAYED;
                            r.send_query = 1'b1;
                        end
                    H_DELAYED:
                        if (span_reached(ev.now, pr_last_query, pr_dead_iv))
                            pr_health = H_DEAD;
                    H_START:
                        if (span_reached(ev.now, pr_restart_at, pr_restart_wait))
                            pr_health = H_ALIVE;
                    default: ;
                endcase
                r.manual_start = pr_manual;
                if (pr_health == H_DEAD && (pr_auto || pr_manual))
                begin
                    pr_manual = 1'b0;
                    pr_health = H_START;
                    pr_restart_at = ev.now;
                    r.start_component = 1'b1;
                end
                if (span_passed(ev.now, pr_last_report, pr_report_iv))
                begin
                    pr_last_report = ev.now;
                    r.send_status = 1'b1;
                end
            end
            ACT_QUERY:
                pr_last_query = ev.now;
            ACT_REPLY:
            begin
                pr_health = H_ALIVE;
                pr_manual = 1'b0;
            end
            default:
                pr_manual = 1'b1;
        endcase
        r.health = pr_health;
        return r;
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_step(input logic [63:0] step_max);
        logic [63:0] w;
        w = {$urandom, $urandom};
        w = w % (step_max + 64'd1);
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] advance_time(input logic [63:0] step_max);
        cur_time = cur_time + rand_step(step_max);
        return cur_time;
    endfunction

    // jump anywhere, step back, or advance
    function automatic logic [TIME_BITS-1:0] noisy_time(input logic [63:0] step_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            cur_time = rand_time();
        else if (r < 50)
            cur_time = cur_time - rand_step(step_max);
        else
            cur_time = cur_time + rand_step(step_max);
        return cur_time;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      results_seen, name, got, exp_v));
    endtask

    task automatic send_event(input logic [1:0] act, input logic [TIME_BITS-1:0] stamp);
        hbm_in_t ev;
        ev.action = act;
        ev.now = stamp;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_liveness(ev));
        items_sent++;
    endtask

    // drop valid and hold until every pending result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_QUERY_INTERVAL:   pr_query_iv = val;
            REG_WARNING_INTERVAL: pr_warn_iv = val;
            REG_DEAD_INTERVAL:    pr_dead_iv = val;
            REG_RESTART_WAIT:     pr_restart_wait = val;
            REG_REPORT_INTERVAL:  pr_report_iv = val;
            REG_AUTO_RESTART:     pr_auto = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] q, input logic [CFG_BITS-1:0] w,
                              input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] rw,
                              input logic [CFG_BITS-1:0] rp, input logic [CFG_BITS-1:0] ar);
        write_reg(REG_QUERY_INTERVAL, q);
        write_reg(REG_WARNING_INTERVAL, w);
        write_reg(REG_DEAD_INTERVAL, d);
        write_reg(REG_RESTART_WAIT, rw);
        write_reg(REG_REPORT_INTERVAL, rp);
        write_reg(REG_AUTO_RESTART, ar);
    endtask

    task automatic run_episode(input logic [63:0] step_max);
        int n;
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 9) < 7)
                send_event(ACT_QUERY, advance_time(step_max));
            n = $urandom_range(2, 14);
            repeat (n) send_event(ACT_POLL, advance_time(step_max));
            case ($urandom_range(0, 2))
                0: send_event(ACT_REPLY, advance_time(step_max));
                1:
                begin
                    send_event(ACT_MANUAL, advance_time(step_max));
                    n = $urandom_range(1, 4);
                    repeat (n) send_event(ACT_POLL, advance_time(step_max));
                end
                default: ;
            endcase
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_event(2'($urandom_range(0, 3)), noisy_time(step_max));
        end
    endtask

    task automatic random_phase(input logic [CFG_BITS-1:0] q, input logic [CFG_BITS-1:0] w,
                                input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] rw,
                                input logic [CFG_BITS-1:0] rp, input logic [CFG_BITS-1:0] ar,
                                input int s_idle, input int r_stall, input int count,
                                input logic [63:0] step_max);
        int start;
        wait_idle();
        set_config(q, w, d, rw, rp, ar);
        send_idle_pct = s_idle;
        recv_stall_pct = r_stall;
        start = items_sent;
        while (items_sent - start < count)
        begin
            run_episode(step_max);
            if ($urandom_range(0, 99) < 4)
                wait_idle();
        end
    endtask

    function automatic logic [CFG_BITS-1:0] rand_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CFG_ALL_ONES;
        if (r == 2)
            return $urandom;
        return $urandom_range(0, 400);
    endfunction

    task automatic test_reset_defaults();
        send_event(ACT_POLL, 48'd0);
        send_event(ACT_POLL, 48'd1999999);
        send_event(ACT_POLL, 48'd2000000);
        send_event(ACT_POLL, 48'd2000001);
        wait_idle();
    endtask

    task automatic test_health_walk();
        set_config(32'd10, 32'd20, 32'd30, 32'd5, 32'd7, 32'd0);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, CFG_ALL_ONES);
        send_event(ACT_POLL, 48'd0);
        send_event(ACT_QUERY, 48'd100);
        send_event(ACT_POLL, 48'd105);
        send_event(ACT_POLL, 48'd110);
        send_event(ACT_POLL, 48'd50);
        send_event(ACT_POLL, 48'd120);
        send_event(ACT_POLL, 48'd130);
        send_event(ACT_POLL, 48'd131);
        send_event(ACT_MANUAL, 48'd132);
        send_event(ACT_POLL, 48'd133);
        send_event(ACT_POLL, 48'd137);
        send_event(ACT_POLL, 48'd138);
        send_event(ACT_REPLY, 48'd139);
        send_event(ACT_QUERY, 48'd140);
        send_event(ACT_POLL, TIME_MAX);
        wait_idle();
    endtask

    task automatic test_extreme_registers();
        set_config('0, '0, '0, '0, '0, 32'd1);
        send_event(ACT_QUERY, TIME_MAX);
        send_event(ACT_POLL, TIME_MAX);
        send_event(ACT_POLL, TIME_MAX);
        send_event(ACT_POLL, TIME_MAX);
        wait_idle();
        set_config(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
                   32'd0);
        send_event(ACT_REPLY, 48'd0);
        send_event(ACT_QUERY, 48'd0);
        send_event(ACT_POLL, 48'hFFFF_FFFE);
        send_event(ACT_POLL, 48'hFFFF_FFFF);
        send_event(ACT_MANUAL, 48'h1_0000_0000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        random_phase(RST_QUERY_INTERVAL, RST_WARNING_INTERVAL, RST_DEAD_INTERVAL,
                     RST_RESTART_WAIT, RST_REPORT_INTERVAL, 32'd0, 0, 0, 180, 64'd1500000);
        random_phase($urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 400),
                     $urandom_range(0, 400), $urandom_range(0, 400), 32'd0, 60, 0, 200, 64'd150);
        random_phase($urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 400),
                     $urandom_range(0, 400), $urandom_range(0, 400), 32'd1, 0, 60, 200, 64'd150);
        random_phase($urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 400),
                     $urandom_range(0, 400), $urandom_range(0, 400), $urandom, 37, 37, 200,
                     64'd150);
        random_phase('0, '0, '0, '0, '0, 32'd0, 0, 0, 150, 64'd3);
        random_phase(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
                     32'd1, 37, 37, 150, 64'd2000000000);
        random_phase(rand_interval(), rand_interval(), rand_interval(), rand_interval(),
                     rand_interval(), $urandom, 0, 0, 200, 64'd500);
    endtask

    task automatic test_backpressure();
        int n;
        repeat (3)
        begin
            wait_idle();
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_left = $urandom_range(40, 120);
            n = 0;
            while (n < 30)
            begin
                send_event(($urandom_range(0, 3) == 0) ? ACT_QUERY : ACT_POLL,
                           advance_time(64'd60));
                n++;
            end
            wait_idle();
            repeat (5) run_episode(64'd60);
        end
    endtask

    // receiver: long holds first, then random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no pending event",
                                          results_seen));
            else
            begin
                want = expected_results.pop_front();
                check_field("send_query", 3'(out_data.send_query), 3'(want.send_query));
                check_field("start_component", 3'(out_data.start_component),
                            3'(want.start_component));
                check_field("manual_start", 3'(out_data.manual_start), 3'(want.manual_start));
                check_field("send_status", 3'(out_data.send_status), 3'(want.send_status));
                check_field("health", out_data.health, want.health);
            end
            results_seen++;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pr_query_iv = RST_QUERY_INTERVAL;
        pr_warn_iv = RST_WARNING_INTERVAL;
        pr_dead_iv = RST_DEAD_INTERVAL;
        pr_restart_wait = RST_RESTART_WAIT;
        pr_report_iv = RST_REPORT_INTERVAL;
        pr_auto = 1'b0;
        pr_health = H_ALIVE;
        pr_last_query = '0;
        pr_restart_at = '0;
        pr_last_report = '0;
        pr_manual = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_health_walk();
        test_extreme_registers();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/hbm_pkg.sv
rtl/hbm_cfg.sv
rtl/hbm_rules.sv
rtl/heartbeat_liveness_monitor.sv
verif/tb_top.sv
